FILE: src/fdseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdseq_pkg: shared types and constants of the flip-dot drive sequencer
// Command descriptor, state encodings, action and acknowledge codes.
// ----------------------------------------------------------------------------
package fdseq_pkg;

  localparam int ROW_LINES_DEF  = 24;
  localparam int COL_LINES_DEF  = 16;
  localparam int CMDQ_DEPTH_DEF = 2;

  localparam int MASK_BITS      = 24;
  localparam int ROW_MASK_BITS  = 16;
  localparam int COL_MASK_BITS  = 24;

  localparam logic [15:0] WHITE_RST = 16'd3000;
  localparam logic [15:0] BLACK_RST = 16'd1500;
  localparam logic [7:0]  MASK_RST  = 8'h42;

  localparam logic REG_WHITE = 1'b0;
  localparam logic REG_BLACK = 1'b1;

  localparam logic [2:0] ACT_ROWBIT = 3'd0;
  localparam logic [2:0] ACT_COLBIT = 3'd1;
  localparam logic [2:0] ACT_STROBE = 3'd2;
  localparam logic [2:0] ACT_WHITE  = 3'd3;
  localparam logic [2:0] ACT_BLACK  = 3'd4;
  localparam logic [2:0] ACT_ACK    = 3'd5;

  localparam logic [7:0] ACK_ROW = 8'd82;
  localparam logic [7:0] ACK_COL = 8'd67;

  localparam logic [5:0] ROW_IDX_OFS = 6'd4;

  typedef enum logic [2:0] {
    PH_READY,
    PH_ROW_M0,
    PH_ROW_M1,
    PH_COL_M0,
    PH_COL_M1,
    PH_COL_M2
  } ph_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INDEX,
    BK_MASK,
    BK_STROBE,
    BK_PULSE,
    BK_ACK
  } bk_t;

  typedef struct packed {
    logic                 is_col;
    logic [5:0]           line_idx;
    logic [MASK_BITS-1:0] mask;
    logic [15:0]          pulse;
  } cmd_t;

endpackage

FILE: src/flipdot_command_drive_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flipdot_command_drive_sequencer: flip-dot command parser and drive sequencer
// Parses received bytes into row and column commands and emits drive runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input bytes are written like a queue: drive push with in_rx_byte while
//   full is low. A command byte with bit 5 set starts a row command (two
//   mask bytes follow); else bit 4 set starts a column command (three mask
//   bytes). Other bytes in the ready phase are dropped silently.
//   Results are read like a queue: while empty is low the oldest result sits
//   on the out_ ports; pop takes it. Within a run one result per cycle is
//   produced while pop stays high. The final mask byte is written into the
//   descriptor queue; the sequencer loads it as its current command and then
//   registers the first result of the run. A row run is ROW_LINES + 19
//   results, a column run COL_LINES + 27; between runs the sequencer
//   fetches the next descriptor, and the sequencer's run length sets the rate.
//   Bytes are taken one per cycle until the descriptor queue (CMDQ_DEPTH
//   commands) fills; then full holds the sender off, nothing is dropped.
//   A stalled reader holds the current result and freezes the sequencer.
//   Reset (rst_n low, synchronous) returns the parser to ready, empties the
//   queue and loads the pulse registers with 3000 and 1500 us.
//   cfg_we writes cfg_wdata to register cfg_index (0 white, 1 black pulse).
// ----------------------------------------------------------------------------
module flipdot_command_drive_sequencer #(
  parameter int ROW_LINES  = fdseq_pkg::ROW_LINES_DEF,
  parameter int COL_LINES  = fdseq_pkg::COL_LINES_DEF,
  parameter int CMDQ_DEPTH = fdseq_pkg::CMDQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_action,
  output logic        out_data_bit,
  output logic [15:0] out_pulse_us,
  output logic [7:0]  out_ack_byte,
  output logic        out_last
);
  import fdseq_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  fdseq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  fdseq_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  fdseq_back #(
    .ROW_LINES (ROW_LINES),
    .COL_LINES (COL_LINES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_cmd        (head_cmd),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_action   (out_action),
    .out_data_bit (out_data_bit),
    .out_pulse_us (out_pulse_us),
    .out_ack_byte (out_ack_byte),
    .out_last     (out_last)
  );

endmodule

FILE: src/fdseq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdseq_front: command byte parser
// Collects a command byte and its mask bytes, then pushes one descriptor.
// ----------------------------------------------------------------------------
module fdseq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output fdseq_pkg::cmd_t     q_cmd
);
  import fdseq_pkg::*;

  ph_t         phase_r, phase_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [7:0]  mask0_r, mask1_r;
  logic [15:0] white_r, black_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READY;
      idx_r   <= '0;
      mask0_r <= MASK_RST;
      mask1_r <= MASK_RST;
      white_r <= WHITE_RST;
      black_r <= BLACK_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WHITE) white_r <= cfg_wdata;
        else                        black_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        if (phase_r == PH_ROW_M0 || phase_r == PH_COL_M0) mask0_r <= rx_byte;
        if (phase_r == PH_ROW_M1 || phase_r == PH_COL_M1) mask1_r <= rx_byte;
      end
    end
  end

  // next phase and line index
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    unique case (phase_r)
      PH_ROW_M0: phase_nxt = PH_ROW_M1;
      PH_ROW_M1: phase_nxt = PH_READY;
      PH_COL_M0: phase_nxt = PH_COL_M1;
      PH_COL_M1: phase_nxt = PH_COL_M2;
      PH_COL_M2: phase_nxt = PH_READY;
      default: begin
        priority if (rx_byte[5]) begin
          phase_nxt = PH_ROW_M0;
          idx_nxt   = {1'b0, rx_byte[4:0]} + ROW_IDX_OFS;
        end else if (rx_byte[4]) begin
          phase_nxt = PH_COL_M0;
          idx_nxt   = {2'b00, rx_byte[3:0]};
        end else begin
          phase_nxt = PH_READY;
        end
      end
    endcase
  end

  // descriptor on the final mask byte
  always_comb begin
    q_push = 1'b0;
    q_cmd  = '0;
    q_cmd.line_idx = idx_r;
    unique case (phase_r)
      PH_ROW_M1: begin
        q_push       = accept;
        q_cmd.is_col = 1'b0;
        q_cmd.mask   = {mask0_r, rx_byte, 8'h00};
        q_cmd.pulse  = white_r;
      end
      PH_COL_M2: begin
        q_push       = accept;
        q_cmd.is_col = 1'b1;
        q_cmd.mask   = {mask0_r, mask1_r, rx_byte};
        q_cmd.pulse  = black_r;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("descriptor pushed into full queue");
`endif

endmodule

FILE: src/fdseq_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdseq_cmdq: command descriptor queue
// Small first-in first-out buffer between parser and drive sequencer.
// ----------------------------------------------------------------------------
module fdseq_cmdq #(
  parameter int DEPTH = fdseq_pkg::CMDQ_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fdseq_pkg::cmd_t wdata,
  input  logic            pop,
  output fdseq_pkg::cmd_t rdata,
  output logic            full,
  output logic            empty
);
  import fdseq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: src/fdseq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdseq_back: drive run sequencer
// Expands one command descriptor into chain bits, strobe, pulse and ack.
// ----------------------------------------------------------------------------
module fdseq_back #(
  parameter int ROW_LINES = fdseq_pkg::ROW_LINES_DEF,
  parameter int COL_LINES = fdseq_pkg::COL_LINES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fdseq_pkg::cmd_t q_cmd,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [2:0]      out_action,
  output logic            out_data_bit,
  output logic [15:0]     out_pulse_us,
  output logic [7:0]      out_ack_byte,
  output logic            out_last
);
  import fdseq_pkg::*;

  localparam int MAXL  = (ROW_LINES > COL_LINES) ? ROW_LINES : COL_LINES;
  localparam int MAXN  = (MAXL > MASK_BITS) ? MAXL : MASK_BITS;
  localparam int CNT_W = $clog2(MAXN);

  bk_t                  state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MASK_BITS-1:0] sh_r, sh_nxt;
  cmd_t                 cur_r;

  logic                 out_valid_r;
  logic [2:0]           act_r;
  logic                 bit_r;
  logic [15:0]          pulse_r;
  logic [7:0]           ack_r;
  logic                 last_r;

  logic                 adv;
  logic                 emit;
  logic [2:0]           act_c;
  logic                 bit_c;
  logic [15:0]          pulse_c;
  logic [7:0]           ack_c;
  logic                 last_c;
  logic [CNT_W-1:0]     idx_end;
  logic [CNT_W-1:0]     mask_end;

  // output stage free or draining this cycle
  assign adv      = !out_valid_r || pop;
  assign idx_end  = cur_r.is_col ? CNT_W'(COL_LINES - 1) : CNT_W'(ROW_LINES - 1);
  assign mask_end = cur_r.is_col ? CNT_W'(COL_MASK_BITS - 1) : CNT_W'(ROW_MASK_BITS - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_INDEX;
          cnt_nxt   = '0;
          sh_nxt    = q_cmd.mask;
        end
      end
      BK_INDEX: begin
        if (adv) begin
          if (cnt_r == idx_end) begin
            state_nxt = BK_MASK;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      BK_MASK: begin
        if (adv) begin
          sh_nxt = {sh_r[MASK_BITS-2:0], 1'b0};
          if (cnt_r == mask_end) begin
            state_nxt = BK_STROBE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      BK_STROBE: if (adv) state_nxt = BK_PULSE;
      BK_PULSE:  if (adv) state_nxt = BK_ACK;
      BK_ACK:    if (adv) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // result for the current step
  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    act_c   = ACT_ROWBIT;
    bit_c   = 1'b0;
    pulse_c = '0;
    ack_c   = '0;
    last_c  = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_INDEX: begin
        emit  = adv;
        act_c = cur_r.is_col ? ACT_COLBIT : ACT_ROWBIT;
        bit_c = (32'(cnt_r) == 32'(cur_r.line_idx));
      end
      BK_MASK: begin
        emit  = adv;
        act_c = cur_r.is_col ? ACT_ROWBIT : ACT_COLBIT;
        bit_c = sh_r[MASK_BITS-1];
      end
      BK_STROBE: begin
        emit  = adv;
        act_c = ACT_STROBE;
      end
      BK_PULSE: begin
        emit    = adv;
        act_c   = cur_r.is_col ? ACT_BLACK : ACT_WHITE;
        pulse_c = cur_r.pulse;
      end
      BK_ACK: begin
        emit   = adv;
        act_c  = ACT_ACK;
        ack_c  = cur_r.is_col ? ACK_COL : ACK_ROW;
        last_c = 1'b1;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit)     out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (q_pop) cur_r <= q_cmd;
    if (emit) begin
      act_r   <= act_c;
      bit_r   <= bit_c;
      pulse_r <= pulse_c;
      ack_r   <= ack_c;
      last_r  <= last_c;
    end
  end

  assign empty        = !out_valid_r;
  assign out_action   = act_r;
  assign out_data_bit = bit_r;
  assign out_pulse_us = pulse_r;
  assign out_ack_byte = ack_r;
  assign out_last     = last_r;

`ifndef SYNTHESIS
  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (act_r == ACT_ACK))
    else $error("last flag on a result other than acknowledge");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == BK_INDEX) && (cnt_r == '0))
    else $error("descriptor taken without starting a run");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_INDEX) |-> (cnt_r <= idx_end))
    else $error("index step counter past chain length");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> out_valid_r)
    else $error("waiting result lost");
`endif

endmodule
